// File: sv/vfc_pkg.sv
// ----------------------------------------------------------------------------
// vfc_pkg
// Shared types and field widths for the voxel face cull core: the neighbour
// select code and the command and status groups between controller and
// datapath.
// ----------------------------------------------------------------------------
package vfc_pkg;

    // Field widths of one input beat and one result beat
    localparam int X_W     = 4;
    localparam int Y_W     = 8;
    localparam int Z_W     = 4;
    localparam int MASK_W  = 6;
    localparam int CNT_W   = 3;
    localparam int SHADE_W = 3;

    // Beat action codes
    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // Which occupancy row an access targets, relative to the addressed cell
    typedef enum logic [2:0] {
        NBR_C,
        NBR_YP,
        NBR_YN,
        NBR_XP,
        NBR_XN
    } t_nbr;

    // Controller to datapath
    typedef struct packed {
        logic load_in;
        logic mem_rd;
        logic mem_wr;
        logic clr_wr;
        t_nbr addr_sel;
        logic cap_en;
        t_nbr cap_sel;
        logic load_out;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
    } t_sts;

endpackage

// File: sv/voxel_face_cull_core.sv
// Items go through one at a time: the input stalls from acceptance until the
// result is loaded; a query reads five occupancy rows through the single memory
// port, one row per cycle.
// Reset: synchronous, active low; afterwards the memory is swept to air, one
// row per cycle over all CHUNK_SPAN*CHUNK_TALL rows (4096 by default), input stalled.
// ----------------------------------------------------------------------------
// voxel_face_cull_core
// Occupancy store for one voxel chunk with exposed-face culling: write beats
// set or clear a cell, query beats return solidity, face mask, face count and shade level.
// ----------------------------------------------------------------------------
module voxel_face_cull_core #(
    parameter int CHUNK_SPAN = 16,
    parameter int CHUNK_TALL = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_action,
    input  logic [vfc_pkg::X_W-1:0]     i_cell_x,
    input  logic [vfc_pkg::Y_W-1:0]     i_cell_y,
    input  logic [vfc_pkg::Z_W-1:0]     i_cell_z,
    input  logic                        i_solid_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_is_solid,
    output logic [vfc_pkg::MASK_W-1:0]  o_face_mask,
    output logic [vfc_pkg::CNT_W-1:0]   o_face_count,
    output logic [vfc_pkg::SHADE_W-1:0] o_shade_quarters
);

    vfc_pkg::t_cmd cmd;
    vfc_pkg::t_sts sts;

    // Sequencer
    vfc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // Memory and result logic
    vfc_dp #(
        .CHUNK_SPAN (CHUNK_SPAN),
        .CHUNK_TALL (CHUNK_TALL)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_action         (i_action),
        .i_cell_x         (i_cell_x),
        .i_cell_y         (i_cell_y),
        .i_cell_z         (i_cell_z),
        .i_solid_in       (i_solid_in),
        .o_is_solid       (o_is_solid),
        .o_face_mask      (o_face_mask),
        .o_face_count     (o_face_count),
        .o_shade_quarters (o_shade_quarters)
    );

endmodule

// File: sv/vfc_dp.sv
// ----------------------------------------------------------------------------
// vfc_dp
// Datapath: occupancy memory organized as one row of z cells per (x, y),
// coordinate registers, neighbour capture registers and result registers.
// ----------------------------------------------------------------------------
module vfc_dp #(
    parameter int CHUNK_SPAN = 16,
    parameter int CHUNK_TALL = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  vfc_pkg::t_cmd               i_cmd,
    output vfc_pkg::t_sts               o_sts,
    input  logic                        i_action,
    input  logic [vfc_pkg::X_W-1:0]     i_cell_x,
    input  logic [vfc_pkg::Y_W-1:0]     i_cell_y,
    input  logic [vfc_pkg::Z_W-1:0]     i_cell_z,
    input  logic                        i_solid_in,
    output logic                        o_is_solid,
    output logic [vfc_pkg::MASK_W-1:0]  o_face_mask,
    output logic [vfc_pkg::CNT_W-1:0]   o_face_count,
    output logic [vfc_pkg::SHADE_W-1:0] o_shade_quarters
);

    localparam int ROWS = CHUNK_SPAN * CHUNK_TALL;
    localparam int RA_W = $clog2(ROWS);

    // Item registers
    logic                    r_is_query;
    logic [vfc_pkg::X_W-1:0] r_x;
    logic [vfc_pkg::Y_W-1:0] r_y;
    logic [vfc_pkg::Z_W-1:0] r_z;
    logic                    r_solid;

    // Memory and its registered read data
    logic [CHUNK_SPAN-1:0] r_mem [ROWS];
    logic [CHUNK_SPAN-1:0] r_rd;
    logic [RA_W-1:0]       r_clr_addr;

    // Captured occupancy of the cell and its neighbours
    logic r_c, r_nz, r_pz, r_py, r_ny, r_px, r_nx;

    logic                    v_c, v_yp, v_yn, v_xp, v_xn;
    logic [vfc_pkg::X_W:0]   xs;
    logic [vfc_pkg::Y_W:0]   ys;
    logic [31:0]             addr_full;
    logic [RA_W-1:0]         mem_addr;
    logic                    mem_we;
    logic [CHUNK_SPAN-1:0]   mem_wdata;
    logic [CHUNK_SPAN-1:0]   zmask;
    logic [CHUNK_SPAN-1:0]   sh_c, sh_m, sh_p;
    logic [vfc_pkg::Z_W-1:0] z_m;
    logic [vfc_pkg::Z_W:0]   z_p;
    logic                    res_solid;
    logic [vfc_pkg::MASK_W-1:0]  res_mask;
    logic [vfc_pkg::CNT_W-1:0]   res_count;
    logic [vfc_pkg::SHADE_W-1:0] res_shade;

    // Bounds of the cell and of each neighbour row
    always_comb begin
        v_c  = (32'(r_x) < CHUNK_SPAN) && (32'(r_y) < CHUNK_TALL) && (32'(r_z) < CHUNK_SPAN);
        v_yp = v_c && ((32'(r_y) + 32'd1) < CHUNK_TALL);
        v_yn = v_c && (r_y != '0);
        v_xp = v_c && ((32'(r_x) + 32'd1) < CHUNK_SPAN);
        v_xn = v_c && (r_x != '0);
    end

    // Select the row coordinates for this access
    always_comb begin
        xs = {1'b0, r_x};
        ys = {1'b0, r_y};
        unique case (i_cmd.addr_sel)
            vfc_pkg::NBR_YP: ys = {1'b0, r_y} + 1'b1;
            vfc_pkg::NBR_YN: ys = {1'b0, r_y} - 1'b1;
            vfc_pkg::NBR_XP: xs = {1'b0, r_x} + 1'b1;
            vfc_pkg::NBR_XN: xs = {1'b0, r_x} - 1'b1;
            default: begin
                xs = {1'b0, r_x};
                ys = {1'b0, r_y};
            end
        endcase
        addr_full = 32'(xs) * 32'(CHUNK_TALL) + 32'(ys);
    end

    // Merge the written cell into its row
    always_comb begin
        zmask     = CHUNK_SPAN'(1) << r_z;
        mem_we    = i_cmd.clr_wr || (i_cmd.mem_wr && v_c);
        mem_addr  = i_cmd.clr_wr ? r_clr_addr : addr_full[RA_W-1:0];
        mem_wdata = i_cmd.clr_wr ? '0 : ((r_rd & ~zmask) | (r_solid ? zmask : '0));
    end

    // Single-port occupancy memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end else if (i_cmd.mem_rd) begin
            r_rd <= r_mem[mem_addr];
        end
    end

    // Advance the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_wr) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    assign o_sts.clr_last = (r_clr_addr == RA_W'(ROWS - 1));

    // Hold the item fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_is_query <= (i_action == vfc_pkg::ACT_QUERY);
            r_x        <= i_cell_x;
            r_y        <= i_cell_y;
            r_z        <= i_cell_z;
            r_solid    <= i_solid_in;
        end
    end

    // Pick the cell bit and its z neighbours out of the row
    always_comb begin
        z_m  = r_z - 1'b1;
        z_p  = {1'b0, r_z} + 1'b1;
        sh_c = r_rd >> r_z;
        sh_m = r_rd >> z_m;
        sh_p = r_rd >> z_p;
    end

    // Capture neighbour occupancy; rows beyond the chunk read as air
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_en) begin
            case (i_cmd.cap_sel)
                vfc_pkg::NBR_C: begin
                    r_c  <= v_c && sh_c[0];
                    r_nz <= v_c && (r_z != '0) && sh_m[0];
                    r_pz <= v_c && sh_p[0];
                end
                vfc_pkg::NBR_YP: r_py <= v_yp && sh_c[0];
                vfc_pkg::NBR_YN: r_ny <= v_yn && sh_c[0];
                vfc_pkg::NBR_XP: r_px <= v_xp && sh_c[0];
                vfc_pkg::NBR_XN: r_nx <= v_xn && sh_c[0];
                default: ;
            endcase
        end
    end

    // Build the result
    always_comb begin
        res_solid = r_is_query && r_c;
        res_mask  = res_solid ? ~{r_nx, r_px, r_ny, r_py, r_pz, r_nz} : '0;
        res_count = '0;
        for (int b = 0; b < vfc_pkg::MASK_W; b++) begin
            res_count = res_count + vfc_pkg::CNT_W'(res_mask[b]);
        end
        if (!res_solid || (r_nz && r_nx)) begin
            res_shade = '0;
        end else begin
            res_shade = 3'd4 - {2'b00, r_nz} - {2'b00, r_nx};
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_is_solid       <= res_solid;
            o_face_mask      <= res_mask;
            o_face_count     <= res_count;
            o_shade_quarters <= res_shade;
        end
    end

endmodule

// File: sv/vfc_ctrl.sv
// ----------------------------------------------------------------------------
// vfc_ctrl
// Controller: runs the clearing sweep after reset, sequences the memory
// accesses of a write or a query and owns the output valid flag.
// ----------------------------------------------------------------------------
module vfc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  logic          i_action,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output vfc_pkg::t_cmd o_cmd,
    input  vfc_pkg::t_sts i_sts
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WRD,
        S_WWR,
        S_QC,
        S_QYP,
        S_QYN,
        S_QXP,
        S_QXN,
        S_QEND,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   n_out_valid;
    logic   out_free;

    assign out_free   = !o_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Decode commands and next state
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_wr = 1'b1;
                if (i_sts.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                o_cmd.load_in = i_in_valid;
                if (i_in_valid) n_state = (i_action == vfc_pkg::ACT_QUERY) ? S_QC : S_WRD;
            end
            S_WRD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_WWR;
            end
            S_WWR: begin
                o_cmd.mem_wr = 1'b1;
                n_state      = S_DONE;
            end
            S_QC: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = S_QYP;
            end
            S_QYP: begin
                o_cmd.mem_rd   = 1'b1;
                o_cmd.addr_sel = vfc_pkg::NBR_YP;
                o_cmd.cap_en   = 1'b1;
                o_cmd.cap_sel  = vfc_pkg::NBR_C;
                n_state        = S_QYN;
            end
            S_QYN: begin
                o_cmd.mem_rd   = 1'b1;
                o_cmd.addr_sel = vfc_pkg::NBR_YN;
                o_cmd.cap_en   = 1'b1;
                o_cmd.cap_sel  = vfc_pkg::NBR_YP;
                n_state        = S_QXP;
            end
            S_QXP: begin
                o_cmd.mem_rd   = 1'b1;
                o_cmd.addr_sel = vfc_pkg::NBR_XP;
                o_cmd.cap_en   = 1'b1;
                o_cmd.cap_sel  = vfc_pkg::NBR_YN;
                n_state        = S_QXN;
            end
            S_QXN: begin
                o_cmd.mem_rd   = 1'b1;
                o_cmd.addr_sel = vfc_pkg::NBR_XN;
                o_cmd.cap_en   = 1'b1;
                o_cmd.cap_sel  = vfc_pkg::NBR_XP;
                n_state        = S_QEND;
            end
            S_QEND: begin
                o_cmd.cap_en  = 1'b1;
                o_cmd.cap_sel = vfc_pkg::NBR_XN;
                n_state       = S_DONE;
            end
            S_DONE: begin
                o_cmd.load_out = out_free;
                if (out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output valid: set on load, drop when the beat is taken
    always_comb begin
        n_out_valid = o_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // State and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            o_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            o_out_valid <= n_out_valid;
        end
    end

`ifndef ASSERT_OFF
    a_stall_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input not stalled after reset");

    a_one_item_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second beat taken while an item is in flight");

    a_one_mem_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.mem_rd, o_cmd.mem_wr, o_cmd.clr_wr}))
        else $error("more than one memory access in a cycle");

    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> !$past(o_cmd.load_out))
        else $error("pending result overwritten");
`endif

endmodule

// File: tb/voxel_face_cull_core_tb.sv
// ----------------------------------------------------------------------------
// voxel_face_cull_core_tb
// Self-checking bench for the voxel face cull core. Write and query beats go
// through a local occupancy predictor that works out the face mask, face
// count and shade for each beat. Every result beat is compared field by field
// with the oldest prediction. Both sides of the handshake idle and stall at
// random. The random part keeps most beats inside small clusters so that
// queries see solid neighbours and chunk boundaries.
// ----------------------------------------------------------------------------
module voxel_face_cull_core_tb;

    localparam int SPAN       = 16;
    localparam int TALL       = 256;
    localparam int CELL_TOTAL = SPAN * TALL * SPAN;

    // Face bit positions in the mask
    localparam int FACE_NZ = 0;
    localparam int FACE_PZ = 1;
    localparam int FACE_PY = 2;
    localparam int FACE_NY = 3;
    localparam int FACE_PX = 4;
    localparam int FACE_NX = 5;

    localparam int MAX_GAP     = 17;
    localparam int TAIL_CYCLES = 24;

    typedef struct packed {
        logic                        is_solid;
        logic [vfc_pkg::MASK_W-1:0]  face_mask;
        logic [vfc_pkg::CNT_W-1:0]   face_count;
        logic [vfc_pkg::SHADE_W-1:0] shade;
    } t_face_result;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_stall;
    logic                        i_action;
    logic [vfc_pkg::X_W-1:0]     i_cell_x;
    logic [vfc_pkg::Y_W-1:0]     i_cell_y;
    logic [vfc_pkg::Z_W-1:0]     i_cell_z;
    logic                        i_solid_in;
    logic                        o_out_valid;
    logic                        i_out_stall;
    logic                        o_is_solid;
    logic [vfc_pkg::MASK_W-1:0]  o_face_mask;
    logic [vfc_pkg::CNT_W-1:0]   o_face_count;
    logic [vfc_pkg::SHADE_W-1:0] o_shade_quarters;

    bit           cell_solid [0:CELL_TOTAL-1];
    t_face_result pending_faces [$];

    int  fail_count;
    int  write_beats;
    int  query_beats;
    int  solid_hits;
    int  results_seen;
    bit  tx_idle_on;
    bit  rx_idle_on;
    int  rx_hold_cycles;

    voxel_face_cull_core #(
        .CHUNK_SPAN (SPAN),
        .CHUNK_TALL (TALL)
    ) u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_cell_x         (i_cell_x),
        .i_cell_y         (i_cell_y),
        .i_cell_z         (i_cell_z),
        .i_solid_in       (i_solid_in),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_is_solid       (o_is_solid),
        .o_face_mask      (o_face_mask),
        .o_face_count     (o_face_count),
        .o_shade_quarters (o_shade_quarters)
    );

    // Free-running clock, period 10
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Occupancy read; anything outside the chunk reads as air
    function automatic bit solid_at(int x, int y, int z);
        if (x < 0 || x >= SPAN || y < 0 || y >= TALL || z < 0 || z >= SPAN) begin
            return 1'b0;
        end
        return cell_solid[(x * TALL + y) * SPAN + z];
    endfunction

    // Apply one beat to the local occupancy copy and work out its result
    function automatic t_face_result cull_cell(bit act, int x, int y, int z, bit solid);
        t_face_result r;
        bit nz, pz, py, ny, px, nx;
        int cnt;
        r = '0;
        if (act == vfc_pkg::ACT_WRITE) begin
            if (x < SPAN && y < TALL && z < SPAN) begin
                cell_solid[(x * TALL + y) * SPAN + z] = solid;
            end
            return r;
        end
        if (!solid_at(x, y, z)) begin
            return r;
        end
        nz = solid_at(x, y, z - 1);
        pz = solid_at(x, y, z + 1);
        py = solid_at(x, y + 1, z);
        ny = solid_at(x, y - 1, z);
        px = solid_at(x + 1, y, z);
        nx = solid_at(x - 1, y, z);
        r.is_solid           = 1'b1;
        r.face_mask[FACE_NZ] = !nz;
        r.face_mask[FACE_PZ] = !pz;
        r.face_mask[FACE_PY] = !py;
        r.face_mask[FACE_NY] = !ny;
        r.face_mask[FACE_PX] = !px;
        r.face_mask[FACE_NX] = !nx;
        cnt = 0;
        for (int b = 0; b < vfc_pkg::MASK_W; b++) begin
            cnt += r.face_mask[b];
        end
        r.face_count = cnt[vfc_pkg::CNT_W-1:0];
        if (nz && nx) begin
            r.shade = '0;
        end else begin
            r.shade = vfc_pkg::SHADE_W'(4 - int'(nz) - int'(nx));
        end
        return r;
    endfunction

    // Idle length for one beat; when enabled, at least a third of draws give no idle at all
    function automatic int draw_gap(bit enabled);
        if (!enabled || $urandom_range(0, 2) == 0) begin
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Offer one beat, hold it until accepted, then record its prediction
    task automatic send_beat(bit act, logic [vfc_pkg::X_W-1:0] x,
                             logic [vfc_pkg::Y_W-1:0] y,
                             logic [vfc_pkg::Z_W-1:0] z, bit solid);
        int           gap;
        t_face_result pred;
        gap = draw_gap(tx_idle_on);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_action   = act;
        i_cell_x   = x;
        i_cell_y   = y;
        i_cell_z   = z;
        i_solid_in = solid;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pred = cull_cell(act, x, y, z, solid);
        pending_faces.insert(pending_faces.size(), pred);
        if (act == vfc_pkg::ACT_WRITE) begin
            write_beats++;
        end else begin
            query_beats++;
            if (pred.is_solid) begin
                solid_hits++;
            end
        end
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic drain_results();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_faces.size() != 0) @(posedge i_clk);
    endtask

    // Receiver: draw a stall per result beat, honor a requested long hold
    initial begin
        int n;
        int hold;
        @(posedge i_rst_n);
        forever begin
            if (rx_hold_cycles > 0) begin
                hold = rx_hold_cycles;
                rx_hold_cycles = 0;
                repeat (hold) begin
                    @(negedge i_clk);
                    i_out_stall = 1'b1;
                end
            end
            n = draw_gap(rx_idle_on);
            repeat (n) begin
                @(negedge i_clk);
                i_out_stall = 1'b1;
            end
            @(negedge i_clk);
            i_out_stall = 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Compare each accepted result beat with the oldest prediction
    always @(posedge i_clk) begin
        t_face_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            if (pending_faces.size() == 0) begin
                $error("result beat with no prediction waiting");
                fail_count++;
            end else begin
                want = pending_faces.pop_front();
                if (o_is_solid !== want.is_solid) begin
                    $error("is_solid: expected %0d, actual %0d", want.is_solid, o_is_solid);
                    fail_count++;
                end
                if (o_face_mask !== want.face_mask) begin
                    $error("face_mask: expected %b, actual %b", want.face_mask, o_face_mask);
                    fail_count++;
                end
                if (o_face_count !== want.face_count) begin
                    $error("face_count: expected %0d, actual %0d",
                           want.face_count, o_face_count);
                    fail_count++;
                end
                if (o_shade_quarters !== want.shade) begin
                    $error("shade_quarters: expected %0d, actual %0d",
                           want.shade, o_shade_quarters);
                    fail_count++;
                end
            end
        end
    end

    // Fresh chunk reads as air, corners included
    task automatic test_reset_air();
        send_beat(vfc_pkg::ACT_QUERY, 4'd0, 8'd0, 4'd0, 1'b0);
        send_beat(vfc_pkg::ACT_QUERY, 4'd15, 8'd255, 4'd15, 1'b1);
        send_beat(vfc_pkg::ACT_QUERY, 4'd7, 8'd128, 4'd9, 1'b0);
    endtask

    // Lone solid cells at the extreme corners expose all six faces
    task automatic test_corners();
        send_beat(vfc_pkg::ACT_WRITE, 4'd0, 8'd0, 4'd0, 1'b1);
        send_beat(vfc_pkg::ACT_QUERY, 4'd0, 8'd0, 4'd0, 1'b0);
        send_beat(vfc_pkg::ACT_WRITE, 4'd15, 8'd255, 4'd15, 1'b1);
        send_beat(vfc_pkg::ACT_QUERY, 4'd15, 8'd255, 4'd15, 1'b1);
    endtask

    // Fill each neighbour of one cell in turn, then clear some back to air
    task automatic test_neighbours();
        send_beat(vfc_pkg::ACT_WRITE, 4'd5, 8'd10, 4'd5, 1'b1);
        send_beat(vfc_pkg::ACT_WRITE, 4'd4, 8'd10, 4'd5, 1'b1);   // -x
        send_beat(vfc_pkg::ACT_QUERY, 4'd5, 8'd10, 4'd5, 1'b0);
        send_beat(vfc_pkg::ACT_WRITE, 4'd5, 8'd10, 4'd4, 1'b1);   // -z, fully shaded
        send_beat(vfc_pkg::ACT_QUERY, 4'd5, 8'd10, 4'd5, 1'b1);
        send_beat(vfc_pkg::ACT_WRITE, 4'd6, 8'd10, 4'd5, 1'b1);   // +x
        send_beat(vfc_pkg::ACT_WRITE, 4'd5, 8'd11, 4'd5, 1'b1);   // +y
        send_beat(vfc_pkg::ACT_WRITE, 4'd5, 8'd9, 4'd5, 1'b1);    // -y
        send_beat(vfc_pkg::ACT_WRITE, 4'd5, 8'd10, 4'd6, 1'b1);   // +z, buried
        send_beat(vfc_pkg::ACT_QUERY, 4'd5, 8'd10, 4'd5, 1'b0);
        send_beat(vfc_pkg::ACT_WRITE, 4'd4, 8'd10, 4'd5, 1'b0);   // clear -x
        send_beat(vfc_pkg::ACT_QUERY, 4'd5, 8'd10, 4'd5, 1'b0);
        send_beat(vfc_pkg::ACT_WRITE, 4'd5, 8'd10, 4'd5, 1'b0);   // clear the cell
        send_beat(vfc_pkg::ACT_QUERY, 4'd5, 8'd10, 4'd5, 1'b1);
        send_beat(vfc_pkg::ACT_QUERY, 4'd6, 8'd10, 4'd5, 1'b0);
    endtask

    // Hold the receiver for a long stretch while the sender keeps offering
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        drain_results();
        rx_hold_cycles = 300;
        for (int i = 0; i < 48; i++) begin
            send_beat(bit'($urandom_range(0, 1)), 4'd2 + 4'($urandom_range(0, 1)),
                      8'd200 + 8'($urandom_range(0, 1)), 4'd3 + 4'($urandom_range(0, 1)),
                      $urandom_range(0, 3) != 0);
        end
        drain_results();
        tx_idle_on = 1'b1;
    endtask

    // Clustered writes and queries with random content and some noise
    task automatic test_random_clusters(int n_batches);
        logic [vfc_pkg::X_W-1:0] bx, x;
        logic [vfc_pkg::Y_W-1:0] by, y;
        logic [vfc_pkg::Z_W-1:0] bz, z;
        bit                      act;
        bit                      solid;
        for (int b = 0; b < n_batches; b++) begin
            tx_idle_on = (b % 4 == 0) || (b % 4 == 2);
            rx_idle_on = (b % 4 == 0) || (b % 4 == 1);
            case ($urandom_range(0, 3))
                0:       bx = '0;
                1:       bx = 4'd13;
                default: bx = 4'($urandom_range(0, 15));
            endcase
            case ($urandom_range(0, 3))
                0:       by = '0;
                1:       by = 8'd253;
                default: by = 8'($urandom_range(0, 255));
            endcase
            case ($urandom_range(0, 3))
                0:       bz = '0;
                1:       bz = 4'd13;
                default: bz = 4'($urandom_range(0, 15));
            endcase
            for (int i = 0; i < 50; i++) begin
                solid = $urandom_range(0, 9) < 7;
                if ($urandom_range(0, 9) == 0) begin
                    // noise beat anywhere in the chunk
                    act = bit'($urandom_range(0, 1));
                    x   = 4'($urandom_range(0, 15));
                    y   = 8'($urandom_range(0, 255));
                    z   = 4'($urandom_range(0, 15));
                end else begin
                    act = (i < 18) ? vfc_pkg::ACT_WRITE : bit'($urandom_range(0, 1));
                    x   = bx + 4'($urandom_range(0, 2));
                    y   = by + 8'($urandom_range(0, 2));
                    z   = bz + 4'($urandom_range(0, 2));
                end
                send_beat(act, x, y, z, solid);
            end
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
    endtask

    // Overall time limit
    initial begin
        #4000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_action       = vfc_pkg::ACT_WRITE;
        i_cell_x       = '0;
        i_cell_y       = '0;
        i_cell_z       = '0;
        i_solid_in     = 1'b0;
        i_out_stall    = 1'b0;
        fail_count     = 0;
        write_beats    = 0;
        query_beats    = 0;
        solid_hits     = 0;
        results_seen   = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        rx_hold_cycles = 0;
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_air();
        test_corners();
        test_neighbours();
        drain_results();
        test_backpressure();
        test_random_clusters(32);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        $display("Ran %0d write and %0d query beats (%0d on solid cells), %0d results checked,",
                 write_beats, query_beats, solid_hits, results_seen);
        $display("with corner, neighbour, long-stall and clustered random traffic.");
        if (fail_count == 0 && pending_faces.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// File: filelist.f
sv/vfc_pkg.sv
sv/vfc_dp.sv
sv/vfc_ctrl.sv
sv/voxel_face_cull_core.sv
tb/voxel_face_cull_core_tb.sv
